// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file vds_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VDS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define VDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/vds_pkg.sv =====
// Shared types and constants of the 2x2x2 mean downsampler.
package vds_pkg;

    localparam int VOX_W       = 16;
    localparam int CFG_W       = 13;
    localparam int SIZE_W      = 11;
    localparam int ZPOS_W      = 12;
    localparam int DEPTH_LIMIT = 4096;
    localparam int SUM_SHIFT   = 3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;

    typedef struct packed {
        logic active;
        logic x_odd;
        logic y_odd;
        logic z_odd;
        logic last;
    } ctrl_t;

endpackage

// ===== rtl/core/vds_seq.sv =====
// Size registers and raster position counters.
module vds_seq #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int XW     = $clog2(MAX_WIDTH),
    localparam int YW     = $clog2(MAX_HEIGHT),
    localparam int HALF_W = MAX_WIDTH / 2,
    localparam int HALF_H = MAX_HEIGHT / 2,
    localparam int CLW    = (HALF_W > 1) ? $clog2(HALF_W) : 1,
    localparam int RLW    = (HALF_H > 1) ? $clog2(HALF_H) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [1:0]                cfg_index,
    input  logic [vds_pkg::CFG_W-1:0] cfg_data,
    input  logic                      step,
    output vds_pkg::ctrl_t            ctrl,
    output logic [CLW-1:0]            col,
    output logic [RLW-1:0]            row_half
);
    import vds_pkg::*;

    localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
    localparam int RST_H = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

    logic [XW-1:0]     wl_reg;
    logic [YW-1:0]     hl_reg;
    logic [ZPOS_W-1:0] dl_reg;
    logic [XW-1:0]     x_reg, x_next;
    logic [YW-1:0]     y_reg, y_next;
    logic [ZPOS_W-1:0] z_reg, z_next;
    logic [SIZE_W-1:0] size_val;
    logic [CFG_W-1:0]  depth_val;
    logic              in_x, in_y, in_z;
    logic              x_last, y_last, z_last;

    assign size_val  = cfg_data[SIZE_W-1:0];
    assign depth_val = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= XW'(RST_W - 1);
            hl_reg <= YW'(RST_H - 1);
            dl_reg <= ZPOS_W'(1023);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_WIDTH:
                begin
                    if (size_val == '0)
                        wl_reg <= '0;
                    else if (32'(size_val) > MAX_WIDTH)
                        wl_reg <= XW'(MAX_WIDTH - 1);
                    else
                        wl_reg <= XW'(size_val - 11'd1);
                end
                REG_HEIGHT:
                begin
                    if (size_val == '0)
                        hl_reg <= '0;
                    else if (32'(size_val) > MAX_HEIGHT)
                        hl_reg <= YW'(MAX_HEIGHT - 1);
                    else
                        hl_reg <= YW'(size_val - 11'd1);
                end
                REG_DEPTH:
                begin
                    if (depth_val == '0)
                        dl_reg <= '0;
                    else if (32'(depth_val) > DEPTH_LIMIT)
                        dl_reg <= ZPOS_W'(DEPTH_LIMIT - 1);
                    else
                        dl_reg <= ZPOS_W'(depth_val - 13'd1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cfg_write_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                             || cfg_index == REG_DEPTH))
        begin
            x_next = '0;
            y_next = '0;
            z_next = '0;
        end
        else if (step)
        begin
            if (x_reg == wl_reg)
            begin
                x_next = '0;
                if (y_reg == hl_reg)
                begin
                    y_next = '0;
                    z_next = (z_reg == dl_reg) ? '0 : z_reg + 1'b1;
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                end
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // an odd size drops its final column, row or plane
    assign in_x = !(x_reg == wl_reg && !wl_reg[0]);
    assign in_y = !(y_reg == hl_reg && !hl_reg[0]);
    assign in_z = !(z_reg == dl_reg && !dl_reg[0]);

    // only evaluated on odd positions, where one of the two compares can hit
    assign x_last = (x_reg == wl_reg) || (x_reg == wl_reg - 1'b1);
    assign y_last = (y_reg == hl_reg) || (y_reg == hl_reg - 1'b1);
    assign z_last = (z_reg == dl_reg) || (z_reg == dl_reg - 1'b1);

    assign ctrl.active = in_x && in_y && in_z;
    assign ctrl.x_odd  = x_reg[0];
    assign ctrl.y_odd  = y_reg[0];
    assign ctrl.z_odd  = z_reg[0];
    assign ctrl.last   = x_last && y_last && z_last;

    assign col      = CLW'(x_reg >> 1);
    assign row_half = RLW'(y_reg >> 1);

endmodule

// ===== rtl/core/vds_acc.sv =====
// Row and plane sum stores, accumulation pipeline and output register.
module vds_acc #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int HALF_W = MAX_WIDTH / 2,
    localparam int HALF_H = MAX_HEIGHT / 2,
    localparam int CLW    = (HALF_W > 1) ? $clog2(HALF_W) : 1,
    localparam int RLW    = (HALF_H > 1) ? $clog2(HALF_H) : 1,
    localparam int PDEPTH = HALF_W * HALF_H,
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [vds_pkg::VOX_W-1:0] voxel,
    input  vds_pkg::ctrl_t            ctrl,
    input  logic [CLW-1:0]            col,
    input  logic [RLW-1:0]            row_half,
    input  logic                      out_ready,
    output logic                      can_accept,
    output logic                      out_valid,
    output logic [vds_pkg::VOX_W-1:0] mean_value,
    output logic                      last_of_volume
);
    import vds_pkg::*;

    logic [VOX_W:0]   row_mem [HALF_W];
    logic [VOX_W+1:0] plane_mem [PDEPTH];

    logic [VOX_W-1:0] held_reg;
    logic [VOX_W:0]   pair;
    logic [PAW-1:0]   pidx;
    logic             row_wr;

    logic [VOX_W:0]   row_q_reg;
    logic [VOX_W+1:0] plane_q_reg;

    logic             s1_valid_reg;
    logic             s1_wr_plane_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic [VOX_W:0]   s1_pair_reg;
    logic [PAW-1:0]   s1_idx_reg;

    logic [VOX_W+1:0] quad;
    logic [VOX_W+2:0] sum;
    logic             s1_adv;

    assign pair   = {1'b0, held_reg} + {1'b0, voxel};
    assign pidx   = PAW'(32'(row_half) * HALF_W + 32'(col));
    assign row_wr = accept && ctrl.active && ctrl.x_odd && !ctrl.y_odd;

    assign quad = {1'b0, row_q_reg} + {1'b0, s1_pair_reg};
    assign sum  = {1'b0, plane_q_reg} + {1'b0, quad};

    // stage 1 holds only when it carries a result and the output is blocked
    assign s1_adv     = !(s1_valid_reg && s1_emit_reg && out_valid && !out_ready);
    assign can_accept = s1_adv;

    always_ff @(posedge clk)
    begin
        if (row_wr)
            row_mem[col] <= pair;
        if (accept)
        begin
            row_q_reg   <= row_mem[col];
            plane_q_reg <= plane_mem[pidx];
        end
        if (s1_valid_reg && s1_wr_plane_reg)
            plane_mem[s1_idx_reg] <= quad;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pair_reg <= pair;
            s1_idx_reg  <= pidx;
            s1_last_reg <= ctrl.last;
        end
        if (s1_valid_reg && s1_emit_reg && s1_adv)
        begin
            mean_value     <= sum[SUM_SHIFT +: VOX_W];
            last_of_volume <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= '0;
            s1_valid_reg    <= 1'b0;
            s1_wr_plane_reg <= 1'b0;
            s1_emit_reg     <= 1'b0;
            out_valid       <= 1'b0;
        end
        else
        begin
            if (accept && ctrl.active && !ctrl.x_odd)
                held_reg <= voxel;
            if (s1_adv)
            begin
                s1_valid_reg    <= accept;
                s1_wr_plane_reg <= ctrl.active && ctrl.x_odd && ctrl.y_odd && !ctrl.z_odd;
                s1_emit_reg     <= ctrl.active && ctrl.x_odd && ctrl.y_odd && ctrl.z_odd;
            end
            if (s1_valid_reg && s1_emit_reg && s1_adv)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/volume_downsample_2x2x2_mean.sv =====
// 2x2x2 floor-of-mean volume downsampler, top level.
// Throughput: one voxel transaction per cycle, sustained unless a result is held back by out_ready low.
// A result is registered in stage 1 and then in the output register after its completing voxel is accepted.
// The registered read of the row and plane sum stores sets the two-stage pipeline.
// Reset: sizes return to 1024 (bounded by MAX_WIDTH/MAX_HEIGHT), positions to zero.
// Sum stores are not cleared; each entry is written before it is read.
module volume_downsample_2x2x2_mean #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [1:0]                cfg_index,
    input  logic [vds_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [vds_pkg::VOX_W-1:0] voxel_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [vds_pkg::VOX_W-1:0] mean_value,
    output logic                      last_of_volume
);
    import vds_pkg::*;

    localparam int HALF_W = MAX_WIDTH / 2;
    localparam int HALF_H = MAX_HEIGHT / 2;
    localparam int CLW    = (HALF_W > 1) ? $clog2(HALF_W) : 1;
    localparam int RLW    = (HALF_H > 1) ? $clog2(HALF_H) : 1;

    ctrl_t          ctrl;
    logic [CLW-1:0] col;
    logic [RLW-1:0] row_half;
    logic           accept;

    assign accept = in_valid && in_ready;

    vds_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (accept),
        .ctrl         (ctrl),
        .col          (col),
        .row_half     (row_half)
    );

    vds_acc #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_acc (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .voxel          (voxel_value),
        .ctrl           (ctrl),
        .col            (col),
        .row_half       (row_half),
        .out_ready      (out_ready),
        .can_accept     (in_ready),
        .out_valid      (out_valid),
        .mean_value     (mean_value),
        .last_of_volume (last_of_volume)
    );

endmodule

// ===== rtl/core/vds_chk.sv =====
// Port-level checker for the downsampler, bound to the top level.
`include "assert_macros.svh"

module vds_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // a pending result is never dropped
    `VDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // a new result only follows an earlier accepted voxel
    `VDS_ASSERT_SAME(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2))
    // input side never stalls while the output register is empty
    `VDS_ASSERT_SAME(a_ready_free, !out_valid, in_ready)

endmodule

bind volume_downsample_2x2x2_mean vds_chk u_vds_chk (.*);
